@@ design/jaic_pkg.sv @@
// Shared constants and controller/datapath command types for the jog axis
// input conditioner. No dependencies; every other design file imports it.
package jaic_pkg;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_LOW_THRESHOLD  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_GAIN     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_SPEED      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SPEED      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE_LIMIT = 3'd4;

   // Field and register widths
   localparam int THRESH_W = 12;
   localparam int GAIN_W   = 16;
   localparam int SPEED_W  = 16;
   localparam int LIMIT_W  = 8;
   localparam int COUNT_W  = 8;

   localparam logic [THRESH_W-1:0] THRESH_RESET = 12'd0;
   localparam logic [GAIN_W-1:0]   GAIN_RESET   = 16'd4096;
   localparam logic [SPEED_W-1:0]  MIN_RESET    = 16'd0;
   localparam logic [SPEED_W-1:0]  MAX_RESET    = 16'hFFFF;
   localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 8'd5;
   localparam logic [COUNT_W-1:0]  COUNT_MAX    = 8'hFF;
   localparam logic [SPEED_W-1:0]  SPEED_MAX    = 16'hFFFF;

   // Speed arithmetic
   localparam int GAIN_FRAC_BITS = 12;
   localparam int DELTA_W        = SPEED_W + 1;   // signed max - min
   localparam int QUOT_W         = DELTA_W + 1;   // biased quotient
   localparam int RES_W          = QUOT_W + 2;    // signed min + quotient - bias

   // Debounced flags
   localparam int FLAG_COUNT    = 4;
   localparam int FLAG_ENABLE   = 0;
   localparam int FLAG_DIR      = 1;
   localparam int FLAG_TRIG_NEG = 2;
   localparam int FLAG_TRIG_POS = 3;

   typedef struct packed {
      logic load;       // capture the word, step the debouncers
      logic mul_frac;   // gain * (sample - threshold) -> fraction
      logic mul_prod;   // (max - min) * fraction + bias -> dividend
      logic fold;       // one end-around fold of the division by full scale
      logic finish;     // load the result register
   } dp_cmd_type;

   typedef struct packed {
      logic fold_done;  // dividend below 2^SAMPLE_BITS
   } dp_status_type;

endpackage

@@ design/jaic_ctrl.sv @@
// Sequencing state machine of the jog axis input conditioner.
// Depends on jaic_pkg for the command and status structs.
module jaic_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output jaic_pkg::dp_cmd_type    dp_cmd,
   input  jaic_pkg::dp_status_type dp_status
);
   import jaic_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MULF = 3'd1;
   localparam logic [2:0] ST_MULP = 3'd2;
   localparam logic [2:0] ST_FOLD = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      dp_cmd   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               dp_cmd.load = 1'b1;
               state_in    = ST_MULF;
            end
         end
         ST_MULF: begin
            dp_cmd.mul_frac = 1'b1;
            state_in        = ST_MULP;
         end
         ST_MULP: begin
            dp_cmd.mul_prod = 1'b1;
            state_in        = ST_FOLD;
         end
         ST_FOLD: begin
            // fold until the dividend fits below full scale plus one
            if (dp_status.fold_done) begin
               state_in = ST_DONE;
            end else begin
               dp_cmd.fold = 1'b1;
            end
         end
         ST_DONE: begin
            // hold until the output register is free or draining
            if (slot_free) begin
               dp_cmd.finish = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (dp_cmd.finish) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

@@ design/jaic_dp.sv @@
// Datapath of the jog axis input conditioner: configuration registers,
// debouncers, shared multiplier, divide-by-full-scale folder, result register.
// Depends on jaic_pkg.
module jaic_dp #(
   parameter int SAMPLE_BITS = 12
) (
   input  logic                            clock,
   input  logic                            reset,
   input  jaic_pkg::dp_cmd_type             dp_cmd,
   output jaic_pkg::dp_status_type          dp_status,
   input  logic                            csr_we,
   input  logic [jaic_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [jaic_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                            req_neg_pin,
   input  logic                            req_pos_pin,
   input  logic [SAMPLE_BITS-1:0]          req_speed_sample,
   input  logic                            req_trig_neg_pin,
   input  logic                            req_trig_pos_pin,
   output logic                            rsp_jog_active,
   output logic                            rsp_direction_positive,
   output logic [jaic_pkg::SPEED_W-1:0]    rsp_speed,
   output logic                            rsp_trigger_neg,
   output logic                            rsp_trigger_pos
);
   import jaic_pkg::*;

   localparam int PROD_W = DELTA_W + SAMPLE_BITS + 1;
   localparam int ACC_W  = PROD_W - 1;
   localparam int HI_W   = ACC_W - SAMPLE_BITS;
   localparam logic [SAMPLE_BITS-1:0] FS = '1;
   // bias that lifts (max - min) * fraction to a non-negative dividend
   localparam logic [PROD_W-1:0] BIAS = PROD_W'(FS) * PROD_W'(SPEED_MAX);

   // configuration
   logic [THRESH_W-1:0] low_threshold_ff;
   logic [GAIN_W-1:0]   speed_gain_ff;
   logic [SPEED_W-1:0]  min_speed_ff;
   logic [SPEED_W-1:0]  max_speed_ff;
   logic [LIMIT_W-1:0]  debounce_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_threshold_ff  <= THRESH_RESET;
         speed_gain_ff     <= GAIN_RESET;
         min_speed_ff      <= MIN_RESET;
         max_speed_ff      <= MAX_RESET;
         debounce_limit_ff <= LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LOW_THRESHOLD:  low_threshold_ff  <= csr_wdata[THRESH_W-1:0];
            CSR_SPEED_GAIN:     speed_gain_ff     <= csr_wdata[GAIN_W-1:0];
            CSR_MIN_SPEED:      min_speed_ff      <= csr_wdata[SPEED_W-1:0];
            CSR_MAX_SPEED:      max_speed_ff      <= csr_wdata[SPEED_W-1:0];
            CSR_DEBOUNCE_LIMIT: debounce_limit_ff <= csr_wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // debouncers
   logic [FLAG_COUNT-1:0] raw_flags;
   logic [FLAG_COUNT-1:0] flags_ff, flags_in;
   logic [COUNT_W-1:0]    counts_ff [FLAG_COUNT];
   logic [COUNT_W-1:0]    counts_in [FLAG_COUNT];

   always_comb begin
      raw_flags[FLAG_ENABLE]   = req_neg_pin ^ req_pos_pin;
      raw_flags[FLAG_DIR]      = req_pos_pin & ~req_neg_pin;
      raw_flags[FLAG_TRIG_NEG] = req_trig_neg_pin;
      raw_flags[FLAG_TRIG_POS] = req_trig_pos_pin;
   end

   always_comb begin
      for (int i = 0; i < FLAG_COUNT; i++) begin
         flags_in[i]  = flags_ff[i];
         counts_in[i] = counts_ff[i];
         if (dp_cmd.load) begin
            if (raw_flags[i] != flags_ff[i]) begin
               if (counts_ff[i] > debounce_limit_ff) begin
                  flags_in[i]  = raw_flags[i];
                  counts_in[i] = '0;
               end else if (counts_ff[i] != COUNT_MAX) begin
                  counts_in[i] = counts_ff[i] + 1'b1;
               end
            end else begin
               counts_in[i] = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
         for (int i = 0; i < FLAG_COUNT; i++) begin
            counts_ff[i] <= '0;
         end
      end else begin
         flags_ff <= flags_in;
         for (int i = 0; i < FLAG_COUNT; i++) begin
            counts_ff[i] <= counts_in[i];
         end
      end
   end

   // speed mapping
   logic [SAMPLE_BITS-1:0]          sample_ff;
   logic [SAMPLE_BITS-1:0]          thresh_n;
   logic [SAMPLE_BITS-1:0]          diff;
   logic signed [DELTA_W-1:0]       delta;
   logic signed [DELTA_W-1:0]       op_a;
   logic signed [SAMPLE_BITS:0]     op_b;
   logic signed [PROD_W-1:0]        product;
   logic [SAMPLE_BITS+3:0]          frac_raw;
   logic [SAMPLE_BITS-1:0]          frac_ff, frac_in;
   logic [PROD_W-1:0]               acc_sum;
   logic [ACC_W-1:0]                acc_ff, acc_in;
   logic [QUOT_W-1:0]               quot_ff, quot_in;
   logic [HI_W-1:0]                 fold_hi;
   logic [SAMPLE_BITS-1:0]          fold_lo;
   logic [QUOT_W-1:0]               quot_final;
   logic signed [RES_W-1:0]         res;
   logic [SPEED_W-1:0]              speed_clamped;

   assign thresh_n = SAMPLE_BITS'(low_threshold_ff);
   assign diff     = (sample_ff > thresh_n) ? (sample_ff - thresh_n) : '0;
   assign delta    = signed'({1'b0, max_speed_ff}) - signed'({1'b0, min_speed_ff});

   // one multiplier, used first for the fraction and then for the span
   always_comb begin
      if (dp_cmd.mul_prod) begin
         op_a = delta;
         op_b = signed'({1'b0, frac_ff});
      end else begin
         op_a = signed'({1'b0, speed_gain_ff});
         op_b = signed'({1'b0, diff});
      end
   end

   assign product  = PROD_W'(op_a) * PROD_W'(op_b);
   assign frac_raw = product[GAIN_W+SAMPLE_BITS-1:GAIN_FRAC_BITS];
   assign frac_in  = (|frac_raw[SAMPLE_BITS+3:SAMPLE_BITS]) ? FS
                                                          : frac_raw[SAMPLE_BITS-1:0];
   assign acc_sum  = $unsigned(product) + BIAS;

   // x = hi * 2^N + lo = hi * (2^N - 1) + (hi + lo)
   assign fold_hi = acc_ff[ACC_W-1:SAMPLE_BITS];
   assign fold_lo = acc_ff[SAMPLE_BITS-1:0];
   assign dp_status.fold_done = (fold_hi == '0);

   always_comb begin
      acc_in  = acc_ff;
      quot_in = quot_ff;
      if (dp_cmd.mul_prod) begin
         acc_in  = acc_sum[ACC_W-1:0];
         quot_in = '0;
      end else if (dp_cmd.fold) begin
         acc_in  = ACC_W'(fold_hi) + ACC_W'(fold_lo);
         quot_in = quot_ff + QUOT_W'(fold_hi);
      end
   end

   // remainder equal to full scale adds one more to the quotient
   assign quot_final = quot_ff + QUOT_W'(acc_ff == ACC_W'(FS));
   assign res = signed'(RES_W'(min_speed_ff)) + signed'(RES_W'(quot_final))
              - signed'(RES_W'(SPEED_MAX));

   always_comb begin
      if (res[RES_W-1]) begin
         speed_clamped = '0;
      end else if (res > signed'(RES_W'(SPEED_MAX))) begin
         speed_clamped = SPEED_MAX;
      end else begin
         speed_clamped = res[SPEED_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.load) begin
         sample_ff <= req_speed_sample;
      end
      if (dp_cmd.mul_frac) begin
         frac_ff <= frac_in;
      end
      acc_ff  <= acc_in;
      quot_ff <= quot_in;
      if (dp_cmd.finish) begin
         rsp_jog_active         <= flags_ff[FLAG_ENABLE];
         rsp_direction_positive <= flags_ff[FLAG_DIR];
         rsp_speed              <= speed_clamped;
         rsp_trigger_neg        <= flags_ff[FLAG_TRIG_NEG];
         rsp_trigger_pos        <= flags_ff[FLAG_TRIG_POS];
      end
   end

endmodule

@@ design/jog_axis_input_conditioner.sv @@
// Jog axis input conditioner: takes one poll word per axis (two jog switch
// pins, a speed potentiometer sample, two auto-trigger pins) and returns one
// result word: debounced jog enable, direction and triggers plus a speed
// command mapped from min_speed to max_speed across the pot range above
// low_threshold, scaled by the Q4.12 speed_gain. One word is in flight at a
// time; a word is accepted, makes two passes through the single shared
// 17 x (SAMPLE_BITS+1) multiplier, then end-around folds divide by full
// scale until the dividend fits below 2^SAMPLE_BITS, then the result
// register is loaded. The result register lets the next request word be
// taken while a finished result still waits on rsp_ready. Configuration
// writes are always ready and belong in idle periods. Debouncer state and
// configuration reset at once.
module jog_axis_input_conditioner #(
   parameter int SAMPLE_BITS = 12
) (
   input  logic                            clock,
   input  logic                            reset,
   // configuration write channel
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [jaic_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [jaic_pkg::CSR_DATA_W-1:0] csr_wdata,
   // request channel
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_neg_pin,
   input  logic                            req_pos_pin,
   input  logic [SAMPLE_BITS-1:0]          req_speed_sample,
   input  logic                            req_trig_neg_pin,
   input  logic                            req_trig_pos_pin,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_jog_active,
   output logic                            rsp_direction_positive,
   output logic [jaic_pkg::SPEED_W-1:0]    rsp_speed,
   output logic                            rsp_trigger_neg,
   output logic                            rsp_trigger_pos
);
   import jaic_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;
   logic          csr_we;

   // accept configuration words on every cycle
   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid & csr_ready;

   jaic_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status)
   );

   jaic_dp #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dp (
      .clock                  (clock),
      .reset                  (reset),
      .dp_cmd                 (dp_cmd),
      .dp_status              (dp_status),
      .csr_we                 (csr_we),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata),
      .req_neg_pin            (req_neg_pin),
      .req_pos_pin            (req_pos_pin),
      .req_speed_sample       (req_speed_sample),
      .req_trig_neg_pin       (req_trig_neg_pin),
      .req_trig_pos_pin       (req_trig_pos_pin),
      .rsp_jog_active         (rsp_jog_active),
      .rsp_direction_positive (rsp_direction_positive),
      .rsp_speed              (rsp_speed),
      .rsp_trigger_neg        (rsp_trigger_neg),
      .rsp_trigger_pos        (rsp_trigger_pos)
   );

   // A taken request word blocks the next one until its result is loaded.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while previous word still in work");

   // Never overwrite a result that has not been taken.
   a_finish_slot_free: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.finish |-> (!rsp_valid || rsp_ready))
      else $error("result register overwritten before it was taken");

   // A loaded result is presented on the next cycle.
   a_finish_shows: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.finish |=> rsp_valid)
      else $error("loaded result not presented");

   // The controller issues at most one datapath command per cycle.
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({dp_cmd.load, dp_cmd.mul_frac, dp_cmd.mul_prod,
                dp_cmd.fold, dp_cmd.finish}))
      else $error("conflicting datapath commands");

endmodule

@@ tb/tb.sv @@
// Self-checking bench for jog_axis_input_conditioner: a scoreboard class
// predicts every result word from the poll words it has seen and checks each
// returned word field by field. Needs jaic_pkg and the conditioner RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import jaic_pkg::*;

   localparam int SAMPLE_BITS  = 12;
   localparam int CLK_HALF     = 5;
   localparam int RESET_CYCLES = 5;
   // Watchdog limit; leaves ample room over the slowest correct run.
   localparam int CYCLE_LIMIT  = 500000;
   // Quiet wait after the final drain, in which stray result words would show.
   localparam int DRAIN_CYCLES = 16;
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MID = 1 << (SAMPLE_BITS - 1);

   // One poll word as it crosses the request channel
   typedef struct packed {
      logic                   neg_pin;
      logic                   pos_pin;
      logic [SAMPLE_BITS-1:0] speed_sample;
      logic                   trig_neg_pin;
      logic                   trig_pos_pin;
   } poll_word_type;

   // One result word as it crosses the response channel
   typedef struct packed {
      logic               jog_active;
      logic               direction_positive;
      logic [SPEED_W-1:0] speed;
      logic               trigger_neg;
      logic               trigger_pos;
   } axis_word_type;

   // Scoreboard: mirrors the register file and debouncer state, predicts one
   // result word per accepted poll word and checks results in order.
   class jog_scoreboard;
      logic [THRESH_W-1:0] thresh_reg;
      logic [GAIN_W-1:0]   gain_reg;
      logic [SPEED_W-1:0]  floor_speed;
      logic [SPEED_W-1:0]  ceil_speed;
      logic [LIMIT_W-1:0]  flag_limit;
      logic                held_flag [FLAG_COUNT];
      logic [COUNT_W-1:0]  mismatch_run [FLAG_COUNT];
      axis_word_type       pending_results [$];
      int unsigned         errors;

      function new();
         thresh_reg  = THRESH_RESET;
         gain_reg    = GAIN_RESET;
         floor_speed = MIN_RESET;
         ceil_speed  = MAX_RESET;
         flag_limit  = LIMIT_RESET;
         for (int i = 0; i < FLAG_COUNT; i++) begin
            held_flag[i]    = 1'b0;
            mismatch_run[i] = '0;
         end
         errors = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_LOW_THRESHOLD:  thresh_reg  = data[THRESH_W-1:0];
            CSR_SPEED_GAIN:     gain_reg    = data[GAIN_W-1:0];
            CSR_MIN_SPEED:      floor_speed = data[SPEED_W-1:0];
            CSR_MAX_SPEED:      ceil_speed  = data[SPEED_W-1:0];
            CSR_DEBOUNCE_LIMIT: flag_limit  = data[LIMIT_W-1:0];
            default: ;
         endcase
      endfunction

      function int unsigned pending();
         return pending_results.size();
      endfunction

      // Take the raw level only after the run of mismatches exceeds the limit.
      function logic step_debouncer(int idx, logic raw);
         if (raw == held_flag[idx]) begin
            mismatch_run[idx] = '0;
         end else if (mismatch_run[idx] > flag_limit) begin
            held_flag[idx]    = raw;
            mismatch_run[idx] = '0;
         end else if (mismatch_run[idx] != COUNT_MAX) begin
            mismatch_run[idx] = mismatch_run[idx] + 1'b1;
         end
         return held_flag[idx];
      endfunction

      // Linear map above the threshold, fraction saturated at full scale,
      // floor division so a falling span rounds toward the lower speed.
      function logic [SPEED_W-1:0] scale_speed(logic [SAMPLE_BITS-1:0] sample);
         longint full_scale, frac, span, prod, quot, rem, res;
         full_scale = (longint'(1) << SAMPLE_BITS) - 1;
         frac = (longint'(sample) > longint'(thresh_reg)) ?
                longint'(sample) - longint'(thresh_reg) : 0;
         frac = (longint'(gain_reg) * frac) >> GAIN_FRAC_BITS;
         if (frac > full_scale)
            frac = full_scale;
         span = longint'(ceil_speed) - longint'(floor_speed);
         prod = span * frac;
         quot = prod / full_scale;
         rem  = prod % full_scale;
         if (rem < 0)
            quot = quot - 1;
         res = longint'(floor_speed) + quot;
         if (res < 0)
            res = 0;
         if (res > longint'(SPEED_MAX))
            res = longint'(SPEED_MAX);
         return res[SPEED_W-1:0];
      endfunction

      function void note_request(poll_word_type w);
         axis_word_type r;
         r.jog_active         = step_debouncer(FLAG_ENABLE, w.neg_pin ^ w.pos_pin);
         r.direction_positive = step_debouncer(FLAG_DIR, w.pos_pin & ~w.neg_pin);
         r.speed              = scale_speed(w.speed_sample);
         r.trigger_neg        = step_debouncer(FLAG_TRIG_NEG, w.trig_neg_pin);
         r.trigger_pos        = step_debouncer(FLAG_TRIG_POS, w.trig_pos_pin);
         pending_results.push_back(r);
      endfunction

      function void compare_field(string name, logic [SPEED_W-1:0] want,
                                  logic [SPEED_W-1:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_response(axis_word_type got);
         axis_word_type want;
         if (pending_results.size() == 0) begin
            $error("result word with none expected: speed %0d", got.speed);
            errors++;
            return;
         end
         want = pending_results.pop_front();
         compare_field("jog_active", SPEED_W'(want.jog_active),
                       SPEED_W'(got.jog_active));
         compare_field("direction_positive", SPEED_W'(want.direction_positive),
                       SPEED_W'(got.direction_positive));
         compare_field("speed", want.speed, got.speed);
         compare_field("trigger_neg", SPEED_W'(want.trigger_neg),
                       SPEED_W'(got.trigger_neg));
         compare_field("trigger_pos", SPEED_W'(want.trigger_pos),
                       SPEED_W'(got.trigger_pos));
      endfunction
   endclass

   // Every block input starts at a known value.
   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic                   req_neg_pin = 1'b0;
   logic                   req_pos_pin = 1'b0;
   logic [SAMPLE_BITS-1:0] req_speed_sample = '0;
   logic                   req_trig_neg_pin = 1'b0;
   logic                   req_trig_pos_pin = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic                   rsp_jog_active;
   logic                   rsp_direction_positive;
   logic [SPEED_W-1:0]     rsp_speed;
   logic                   rsp_trigger_neg;
   logic                   rsp_trigger_pos;

   // Percent of cycles in which the sender idles and the receiver stalls
   int unsigned send_idle_pct = 0;
   int unsigned stall_pct     = 0;
   int unsigned cycle_count   = 0;

   jog_scoreboard sb;

   jog_axis_input_conditioner #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_dut (
      .clock                  (clock),
      .reset                  (reset),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_neg_pin            (req_neg_pin),
      .req_pos_pin            (req_pos_pin),
      .req_speed_sample       (req_speed_sample),
      .req_trig_neg_pin       (req_trig_neg_pin),
      .req_trig_pos_pin       (req_trig_pos_pin),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_jog_active         (rsp_jog_active),
      .rsp_direction_positive (rsp_direction_positive),
      .rsp_speed              (rsp_speed),
      .rsp_trigger_neg        (rsp_trigger_neg),
      .rsp_trigger_pos        (rsp_trigger_pos)
   );

   always #CLK_HALF clock = ~clock;

   // Watchdog: abort a run that exceeds the cycle limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("jog_axis_input_conditioner verification failed");
         $finish;
      end
   end

   // Receiver: check each word taken at this edge, then pick the next ready.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response({rsp_jog_active, rsp_direction_positive, rsp_speed,
                            rsp_trigger_neg, rsp_trigger_pos});
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // Hold one register write until taken; the caller drops csr_valid.
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      sb.write_reg(idx, data);
   endtask

   task automatic program_regs(logic [THRESH_W-1:0] thr, logic [GAIN_W-1:0] gain,
                               logic [SPEED_W-1:0] lo, logic [SPEED_W-1:0] hi,
                               logic [LIMIT_W-1:0] lim);
      write_csr(CSR_LOW_THRESHOLD, CSR_DATA_W'(thr));
      write_csr(CSR_SPEED_GAIN, gain);
      write_csr(CSR_MIN_SPEED, lo);
      write_csr(CSR_MAX_SPEED, hi);
      write_csr(CSR_DEBOUNCE_LIMIT, CSR_DATA_W'(lim));
      csr_valid <= 1'b0;
   endtask

   // Drop valid and wait until every predicted word has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // Send one poll word; optionally drain first, otherwise idle at random.
   // Returns at the edge that took the word, so the next call drives once.
   task automatic send_word(poll_word_type w, bit hold);
      if (hold) begin
         drain_results();
      end else if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      {req_neg_pin, req_pos_pin, req_speed_sample, req_trig_neg_pin,
       req_trig_pos_pin} <= w;
      do @(posedge clock); while (!(req_valid && req_ready));
      sb.note_request(w);
   endtask

   // Mostly steady pin patterns held long enough to pass the debouncer, with
   // contact bounce mixed in; runs shorter than the limit act as broken presses.
   task automatic run_random(int unsigned n_words);
      poll_word_type w;
      logic [3:0]    held_pins;
      int unsigned   run_left;
      held_pins = 4'($urandom);
      run_left  = 0;
      repeat (n_words) begin
         if (run_left == 0) begin
            held_pins = 4'($urandom);
            run_left  = $urandom_range(1, 2 * sb.flag_limit + 6);
         end
         run_left--;
         {w.neg_pin, w.pos_pin, w.trig_neg_pin, w.trig_pos_pin} = held_pins;
         if ($urandom_range(7) == 0)
            {w.neg_pin, w.pos_pin, w.trig_neg_pin, w.trig_pos_pin} =
               held_pins ^ 4'($urandom_range(1, 15));
         case ($urandom_range(7))
            0:       w.speed_sample = '0;
            1:       w.speed_sample = SAMPLE_MAX;
            2:       w.speed_sample = SAMPLE_BITS'(sb.thresh_reg + $urandom_range(2) - 1);
            default: w.speed_sample = SAMPLE_BITS'($urandom);
         endcase
         send_word(w, $urandom_range(63) == 0);
      end
   endtask

   initial begin
      poll_word_type       w;
      logic [THRESH_W-1:0] thr;
      logic [GAIN_W-1:0]   gain;
      logic [SPEED_W-1:0]  lo;
      logic [SPEED_W-1:0]  hi;
      logic [SPEED_W-1:0]  swap;
      logic [LIMIT_W-1:0]  lim;
      int unsigned         n_words;
      int unsigned         full_gain;

      sb = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Reset settings, limit 5: press positive with the negative trigger,
      // then negative with the positive trigger, then both jog switches.
      // The first two holds are long enough for the flags to flip on the seventh word;
      // pause for a full drain before the both-pressed stretch.
      for (int k = 0; k < 19; k++) begin
         w.neg_pin      = (k >= 8);
         w.pos_pin      = (k < 8) || (k >= 16);
         w.trig_neg_pin = (k < 8);
         w.trig_pos_pin = (k >= 8) && (k < 16);
         case (k % 4)
            0:       w.speed_sample = '0;
            1:       w.speed_sample = SAMPLE_MAX;
            2:       w.speed_sample = 1;
            default: w.speed_sample = SAMPLE_MID;
         endcase
         send_word(w, k == 16);
      end

      // Gain overflow with a falling span and a limit the count can't exceed.
      drain_results();
      program_regs('0, 16'hFFFF, 16'hFFFF, 16'h0000, 8'hFF);
      for (int k = 0; k < 5; k++) begin
         {w.neg_pin, w.pos_pin, w.trig_neg_pin, w.trig_pos_pin} = 4'($urandom);
         case (k)
            0:       w.speed_sample = '0;
            1:       w.speed_sample = 1;
            2:       w.speed_sample = 2;
            3:       w.speed_sample = SAMPLE_MAX;
            default: w.speed_sample = 100;
         endcase
         send_word(w, 1'b0);
      end

      // Random phases: each takes a new register setting and idling mode.
      for (int ph = 0; ph < 8; ph++) begin
         thr     = THRESH_W'($urandom);
         gain    = GAIN_W'($urandom);
         lo      = SPEED_W'($urandom);
         hi      = SPEED_W'($urandom);
         lim     = LIMIT_W'($urandom_range(0, 6));
         n_words = 180;
         case (ph)
            0: begin
               // widest gain, full span, flags follow after one stable word
               thr  = '0;
               gain = 16'hFFFF;
               lo   = '0;
               hi   = 16'hFFFF;
               lim  = '0;
            end
            1: begin
               // threshold at full scale pins speed to min; span falls
               thr  = '1;
               gain = GAIN_RESET;
               lo   = 16'hFFFF;
               hi   = '0;
               lim  = 1;
            end
            2: begin
               // gain set to full scale over the remaining range, rising span
               thr       = THRESH_W'($urandom_range(0, 3000));
               full_gain = (4096 * 4095) / (4095 - thr);
               gain      = (full_gain > 16'hFFFF) ? 16'hFFFF : GAIN_W'(full_gain);
               if (lo > hi) begin
                  swap = lo;
                  lo   = hi;
                  hi   = swap;
               end
               lim = 2;
            end
            3: begin
               // zero gain, largest limit that the count can still exceed
               gain    = '0;
               lim     = 8'd254;
               n_words = 150;
            end
            4: begin
               thr  = 2000;
               gain = 8006;
               lo   = 16'hFFFF;
               hi   = '0;
            end
            5: begin
               // count saturates at its top; flags stay where they are
               lim     = 8'hFF;
               n_words = 400;
            end
            6: hi = lo;
            default: ;
         endcase
         drain_results();
         program_regs(thr, gain, lo, hi, lim);
         case (ph % 4)
            0: begin
               send_idle_pct = 0;
               stall_pct     = 0;
            end
            1: begin
               send_idle_pct = 63;
               stall_pct     = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct     = 63;
            end
            default: begin
               send_idle_pct = 36;
               stall_pct     = 36;
            end
         endcase
         run_random(n_words);
      end

      // Wait out every expected word, then watch for strays.
      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0)
         $display("jog_axis_input_conditioner verification clean");
      else
         $display("jog_axis_input_conditioner verification failed");
      $finish;
   end

endmodule

@@ filelist.f @@
design/jaic_pkg.sv
design/jaic_ctrl.sv
design/jaic_dp.sv
design/jog_axis_input_conditioner.sv
tb/tb.sv
